@@ rtl/tprt_pkg.sv @@
// Shared types and constants for the transport PID remap table.
`timescale 1ns / 1ps
package tprt_pkg;
   localparam logic [1:0] CMD_MAP_PID   = 2'd0;
   localparam logic [1:0] CMD_UNMAP_PID = 2'd1;
   localparam logic [1:0] CMD_MAP_SID   = 2'd2;
   localparam logic [1:0] CMD_CLEAR     = 2'd3;
   localparam logic [15:0] SAT16 = 16'hFFFF;
   localparam int PID_W = 13;
   localparam int PID_SPACE = 8192;
endpackage

@@ rtl/transport_pid_remap_table.sv @@
// Top level of the transport PID remap table.
`timescale 1ns / 1ps
// Usage: one command word enters on req_ (tdata = command, pid_value, sid_value from
// bit 0 up), one result word leaves on rsp_ (tdata = mapped_value, hit, table_full,
// miss_count from bit 0 up). csr_ writes mtd_number at any clock with csr_wr_en.
// One word is worked on at a time. A map_pid miss walks the reverse-map valid bits
// one slot a cycle. map_sid reads the SID list one entry at a time, as each compare
// waits on the registered read. clear answers as it starts a clearing pass over the
// 8192-entry forward map, one entry a cycle, during which no word is accepted.
// Reset starts the same pass once reset is released. Reverse-map valid bits are
// flip-flops cleared at once. The result waits in an output register while the
// receiver stalls; the next word can be accepted in the cycle after it is taken,
// once any clearing pass is done.
module transport_pid_remap_table #(
   parameter int UNIQUE_SLOTS = 256,
   parameter int SID_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command[1:0], pid_value[14:2], sid_value[30:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // mapped_value[15:0], hit, table_full, miss_count[33:18]
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   localparam int SW = $clog2(UNIQUE_SLOTS);
   localparam int LW = $clog2(SID_SLOTS);
   localparam int CW = LW + 1;
   localparam logic [3:0] ST_WIPE = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2, ST_FWD = 4'd3,
      ST_SCAN = 4'd4, ST_UNMAP = 4'd5, ST_SID = 4'd6, ST_OUT = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [4:0] mtd_ff;
   logic [12:0] wipe_ff;
   logic [1:0] cmd_ff;
   logic [12:0] pid_ff;
   logic [15:0] sid_ff;
   logic [SW-1:0] next_ff, scan_ff;
   logic [SW:0] scan_n_ff;
   logic [UNIQUE_SLOTS-1:0] rv_ff;
   logic [CW-1:0] sid_cnt_ff;
   logic [LW-1:0] sid_i_ff;
   logic [15:0] miss_ff;
   logic [15:0] val_ff;
   logic hit_ff, full_ff, rsp_v_ff;

   logic [12:0] fwd_mem [tprt_pkg::PID_SPACE];
   logic [12:0] rev_mem [UNIQUE_SLOTS];
   logic [15:0] sid_mem [SID_SLOTS];
   logic [12:0] fwd_rd_ff, rev_rd_ff;
   logic [15:0] sid_rd_ff;
   logic [SW-1:0] ps;
   logic [SW:0] slot_full;
   logic [7:0] uslot;

   assign ps = scan_ff;
   assign uslot = pid_ff[7:0];
   assign slot_full = {1'b0, ps} + 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {6'd0, miss_ff, full_ff, hit_ff, val_ff};

   // memory reads, one per cycle
   always_ff @(posedge clock) begin
      fwd_rd_ff <= fwd_mem[pid_ff];
      rev_rd_ff <= rev_mem[ps];
      sid_rd_ff <= sid_mem[sid_i_ff];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WIPE:  if (wipe_ff == 13'h1FFF) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid && req_tready) state_in = ST_RD;
         default:  state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE; wipe_ff <= '0; mtd_ff <= 5'd1; next_ff <= '0;
         rv_ff <= '0; sid_cnt_ff <= '0; miss_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mtd_ff <= csr_wr_data;
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         case (state_ff)
            ST_WIPE: begin
               // clear one forward-map entry per cycle
               fwd_mem[wipe_ff] <= '0;
               wipe_ff <= wipe_ff + 13'd1;
               state_ff <= state_in;
            end
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cmd_ff <= req_tdata[1:0];
                  pid_ff <= req_tdata[14:2];
                  sid_ff <= req_tdata[30:15];
                  scan_ff <= next_ff;
                  scan_n_ff <= '0;
                  sid_i_ff <= '0;
                  state_ff <= state_in;
               end
            end
            ST_RD: begin
               val_ff <= '0; hit_ff <= 1'b0; full_ff <= 1'b0;
               case (cmd_ff)
                  tprt_pkg::CMD_MAP_PID: state_ff <= ST_FWD;
                  tprt_pkg::CMD_UNMAP_PID: begin
                     if ({24'd0, uslot} < UNIQUE_SLOTS && rv_ff[uslot[SW-1:0]]) begin
                        scan_ff <= uslot[SW-1:0];
                        state_ff <= ST_UNMAP;
                     end else begin
                        if (miss_ff != tprt_pkg::SAT16) miss_ff <= miss_ff + 16'd1;
                        state_ff <= ST_OUT;
                     end
                  end
                  tprt_pkg::CMD_MAP_SID: state_ff <= ST_SID;
                  default: begin
                     rv_ff <= '0; sid_cnt_ff <= '0; miss_ff <= '0;
                     wipe_ff <= '0;
                     rsp_v_ff <= 1'b1;
                     state_ff <= ST_WIPE;
                  end
               endcase
            end
            ST_FWD: begin
               if (fwd_rd_ff != '0) begin
                  val_ff <= {3'd0, fwd_rd_ff}; hit_ff <= 1'b1; state_ff <= ST_OUT;
               end else state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // walk slots from next pointer, one a cycle
               if (scan_n_ff == UNIQUE_SLOTS[SW:0]) begin
                  full_ff <= 1'b1; state_ff <= ST_OUT;
               end else if (!rv_ff[ps]) begin
                  rv_ff[ps] <= 1'b1;
                  rev_mem[ps] <= pid_ff;
                  val_ff <= {3'd0, mtd_ff, 8'(ps)};
                  fwd_mem[pid_ff] <= {mtd_ff, 8'(ps)};
                  next_ff <= (slot_full == UNIQUE_SLOTS[SW:0]) ? '0 : slot_full[SW-1:0];
                  hit_ff <= 1'b1; state_ff <= ST_OUT;
               end else begin
                  scan_ff <= (slot_full == UNIQUE_SLOTS[SW:0]) ? '0 : slot_full[SW-1:0];
                  scan_n_ff <= scan_n_ff + 1'b1;
               end
            end
            ST_UNMAP: begin
               // wait for the registered read of the reverse map
               if (scan_n_ff[0]) begin
                  val_ff <= {3'd0, rev_rd_ff}; hit_ff <= 1'b1; state_ff <= ST_OUT;
               end else scan_n_ff <= scan_n_ff + 1'b1;
            end
            ST_SID: begin
               // walk SID list; scan_n_ff[0] marks read data valid for sid_i_ff
               if ({1'b0, sid_i_ff} == sid_cnt_ff) begin
                  if (sid_cnt_ff == SID_SLOTS[CW-1:0]) full_ff <= 1'b1;
                  else begin
                     sid_mem[sid_i_ff] <= sid_ff;
                     sid_cnt_ff <= sid_cnt_ff + 1'b1;
                     val_ff <= {3'd0, mtd_ff, 8'(sid_i_ff)}; hit_ff <= 1'b1;
                  end
                  state_ff <= ST_OUT;
               end else if (!scan_n_ff[0]) scan_n_ff[0] <= 1'b1;
               else if (sid_rd_ff == sid_ff) begin
                  val_ff <= {3'd0, mtd_ff, 8'(sid_i_ff)}; hit_ff <= 1'b1; state_ff <= ST_OUT;
               end else begin
                  scan_n_ff[0] <= 1'b0;
                  if ({1'b0, sid_i_ff} == SID_SLOTS[CW-1:0] - 1'b1) begin
                     full_ff <= 1'b1; state_ff <= ST_OUT;
                  end else sid_i_ff <= sid_i_ff + 1'b1;
               end
            end
            ST_OUT: begin
               rsp_v_ff <= 1'b1; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a result is never shown while a word is being accepted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   a_hit_nofull: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && rsp_tdata[17])) else $error("hit with full");
   a_sid_cnt: assert property (@(posedge clock) disable iff (reset)
      sid_cnt_ff <= SID_SLOTS[CW-1:0]) else $error("sid count overflow");
endmodule
